// ===== hw/rtl/ptsc_pkg.sv =====
`default_nettype none
package ptsc_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int IDX_W     = 6;
  localparam int LINK_W    = 7;
  localparam logic [LINK_W-1:0] SLOT_NONE = LINK_W'(NUM_SLOTS);

  // operation codes
  localparam logic [3:0] OP_CLEAR    = 4'd0;
  localparam logic [3:0] OP_CREATE   = 4'd1;
  localparam logic [3:0] OP_CHILD    = 4'd2;
  localparam logic [3:0] OP_KILL     = 4'd3;
  localparam logic [3:0] OP_KILL_ALL = 4'd4;
  localparam logic [3:0] OP_FIND     = 4'd5;
  localparam logic [3:0] OP_FRAME    = 4'd6;
  localparam logic [3:0] OP_RUN      = 4'd7;
  localparam logic [3:0] OP_SLEEP    = 4'd8;
  localparam logic [3:0] OP_EXIT     = 4'd9;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_FREE     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [2:0] ST_KILLED_SELF = 3'd3;
  localparam logic [2:0] ST_FRAME_DONE  = 3'd4;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] task_tag;
    logic [31:0] proc_id;
    logic [31:0] id_mask;
    logic [5:0]  slot;
    logic [15:0] ticks;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [LINK_W-1:0] result_slot;
    logic [31:0]       result_tag;
  } rsp_t;

  function automatic logic slot_valid(input logic [LINK_W-1:0] s);
    return s < SLOT_NONE;
  endfunction

  function automatic rsp_t mk_rsp(input logic [2:0] st, input logic [LINK_W-1:0] s,
                                  input logic [31:0] tg);
    rsp_t r;
    r.status      = st;
    r.result_slot = s;
    r.result_tag  = tg;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/process_table_scheduler.sv =====
`default_nettype none
// Task slot scheduler over 64 slots kept as a free list and an ordered active list.
// Command channel: drive req_i and raise start; the command transfers on the rising
// edge where start is high and busy is low. busy stays high until the result is out.
// Result channel: rsp_o is valid for exactly one cycle while done_o is high; the
// receiver cannot stall, so it must take the result in that cycle.
// Sequence: clear, frame start, sleep and the error cases of create, sleep and exit
// answer straight from idle with a registered result. Create pops the free list in
// S_CR_LINK; create as child then also passes S_CR_CHILD and S_CR_SPLICE. Kill, kill
// all, find, exit and run next walk the active list through the link memory, one slot
// per cycle, and each slot that is unlinked also passes S_FREE to join the free list.
// The single read port of the link memory sets this pace.
// A new command may be taken in the cycle in which done_o is high.
// Reset: the free list holds every slot in order, the active list is empty and no
// task is current. Link entries never written read as their reset successor, so no
// clearing pass is needed; the clear command does the same by dropping the written marks.
module process_table_scheduler
  import ptsc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire req_t req_i,
  output logic      busy,
  output logic      done_o,
  output rsp_t      rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR_LINK,
    S_CR_CHILD,
    S_CR_SPLICE,
    S_WALK,
    S_FREE
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        op_q, op_d;
  logic [31:0]       tag_q, tag_d, pid_q, pid_d, mask_q, mask_d;
  logic [LINK_W-1:0] c_q, c_d, prev_q, prev_d, tgt_q, tgt_d;
  logic [IDX_W-1:0]  steps_q, steps_d;
  logic              self_q, self_d, more_q, more_d;
  logic [LINK_W-1:0] free_q, free_d, head_q, head_d, cur_q, cur_d, cursor_q, cursor_d;
  logic              done_d;
  rsp_t              rsp_q, rsp_d;

  // memory ports
  logic              link_clr, link_we;
  logic [IDX_W-1:0]  link_waddr, rd_addr;
  logic [LINK_W-1:0] link_wdata, link_rdata;
  logic              data_we, sc_we;
  logic [IDX_W-1:0]  data_waddr, sc_waddr;
  logic [15:0]       sc_wdata, sc_rdata;
  logic [31:0]       id_rdata, tag_rdata;

  logic [LINK_W-1:0] nxt;
  logic              last, match;
  logic [15:0]       sc_dec;

  ptsc_link u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (link_clr),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  ptsc_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (pid_q),
    .raddr_i (rd_addr),
    .rdata_o (id_rdata)
  );

  ptsc_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (tag_q),
    .raddr_i (rd_addr),
    .rdata_o (tag_rdata)
  );

  ptsc_ram #(.WIDTH(16), .DEPTH(NUM_SLOTS)) u_sleep_ram (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (sc_wdata),
    .raddr_i (rd_addr),
    .rdata_o (sc_rdata)
  );

  // values of the slot read in the previous cycle
  assign nxt    = link_rdata;
  assign last   = !slot_valid(nxt) || (steps_q == IDX_W'(NUM_SLOTS - 1));
  assign match  = (id_rdata & mask_q) == (pid_q & mask_q);
  assign sc_dec = (sc_rdata == 16'd0) ? 16'd0 : sc_rdata - 16'd1;

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    tag_d      = tag_q;
    pid_d      = pid_q;
    mask_d     = mask_q;
    c_d        = c_q;
    prev_d     = prev_q;
    tgt_d      = tgt_q;
    steps_d    = steps_q;
    self_d     = self_q;
    more_d     = more_q;
    free_d     = free_q;
    head_d     = head_q;
    cur_d      = cur_q;
    cursor_d   = cursor_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    link_clr   = 1'b0;
    link_we    = 1'b0;
    link_waddr = tgt_q[IDX_W-1:0];
    link_wdata = free_q;
    rd_addr    = c_q[IDX_W-1:0];
    data_we    = 1'b0;
    data_waddr = tgt_q[IDX_W-1:0];
    sc_we      = 1'b0;
    sc_waddr   = c_q[IDX_W-1:0];
    sc_wdata   = 16'd0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = req_i.op;
          tag_d   = req_i.task_tag;
          pid_d   = req_i.proc_id;
          mask_d  = req_i.id_mask;
          prev_d  = SLOT_NONE;
          steps_d = '0;
          self_d  = 1'b0;
          case (req_i.op)
            OP_CLEAR: begin
              link_clr = 1'b1;
              free_d   = '0;
              head_d   = SLOT_NONE;
              cur_d    = SLOT_NONE;
              cursor_d = SLOT_NONE;
              done_d   = 1'b1;
              rsp_d    = mk_rsp(ST_OK, SLOT_NONE, '0);
            end
            OP_CREATE, OP_CHILD: begin
              if (slot_valid(free_q)) begin
                tgt_d   = free_q;
                rd_addr = free_q[IDX_W-1:0];
                state_d = S_CR_LINK;
              end else begin
                done_d = 1'b1;
                rsp_d  = mk_rsp(ST_NO_FREE, SLOT_NONE, '0);
              end
            end
            OP_KILL, OP_KILL_ALL, OP_FIND: begin
              tgt_d  = {1'b0, req_i.slot};
              self_d = slot_valid(cur_q) && ({1'b0, req_i.slot} == cur_q);
              if (slot_valid(head_q)) begin
                c_d     = head_q;
                rd_addr = head_q[IDX_W-1:0];
                state_d = S_WALK;
              end else begin
                done_d = 1'b1;
                rsp_d  = mk_rsp((req_i.op == OP_KILL_ALL) ? ST_OK : ST_NOT_FOUND,
                                SLOT_NONE, '0);
              end
            end
            OP_FRAME: begin
              cursor_d = head_q;
              cur_d    = SLOT_NONE;
              done_d   = 1'b1;
              rsp_d    = mk_rsp(ST_OK, SLOT_NONE, '0);
            end
            OP_RUN: begin
              cur_d = SLOT_NONE;
              if (slot_valid(cursor_q)) begin
                c_d     = cursor_q;
                rd_addr = cursor_q[IDX_W-1:0];
                state_d = S_WALK;
              end else begin
                cursor_d = SLOT_NONE;
                done_d   = 1'b1;
                rsp_d    = mk_rsp(ST_FRAME_DONE, SLOT_NONE, '0);
              end
            end
            OP_SLEEP: begin
              done_d = 1'b1;
              if (slot_valid(cur_q)) begin
                sc_we    = 1'b1;
                sc_waddr = cur_q[IDX_W-1:0];
                sc_wdata = req_i.ticks;
                rsp_d    = mk_rsp(ST_OK, cur_q, '0);
              end else begin
                rsp_d = mk_rsp(ST_NOT_FOUND, SLOT_NONE, '0);
              end
            end
            OP_EXIT: begin
              if (slot_valid(cur_q)) begin
                tgt_d   = cur_q;
                c_d     = head_q;
                rd_addr = head_q[IDX_W-1:0];
                state_d = S_WALK;
              end else begin
                done_d = 1'b1;
                rsp_d  = mk_rsp(ST_NOT_FOUND, SLOT_NONE, '0);
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = mk_rsp(ST_OK, SLOT_NONE, '0);
            end
          endcase
        end
      end

      // pop the free list, fill the slot
      S_CR_LINK: begin
        free_d   = nxt;
        data_we  = 1'b1;
        sc_we    = 1'b1;
        sc_waddr = tgt_q[IDX_W-1:0];
        sc_wdata = 16'd0;
        if (op_q == OP_CHILD && slot_valid(cur_q) && cur_q != tgt_q) begin
          rd_addr = cur_q[IDX_W-1:0];
          state_d = S_CR_CHILD;
        end else begin
          link_we    = 1'b1;
          link_wdata = head_q;
          head_d     = tgt_q;
          done_d     = 1'b1;
          rsp_d      = mk_rsp(ST_OK, tgt_q, '0);
          state_d    = S_IDLE;
        end
      end

      // link the child to the current task's successor
      S_CR_CHILD: begin
        link_we    = 1'b1;
        link_wdata = nxt;
        state_d    = S_CR_SPLICE;
      end

      S_CR_SPLICE: begin
        link_we    = 1'b1;
        link_waddr = cur_q[IDX_W-1:0];
        link_wdata = tgt_q;
        done_d     = 1'b1;
        rsp_d      = mk_rsp(ST_OK, tgt_q, '0);
        state_d    = S_IDLE;
      end

      // one slot of the list per cycle, unless a slot is unlinked and goes to S_FREE
      S_WALK: begin
        case (op_q)
          OP_KILL, OP_EXIT, OP_KILL_ALL: begin
            if ((op_q == OP_KILL_ALL) ? (match && c_q != cur_q) : (c_q == tgt_q)) begin
              // unlink this slot
              if (slot_valid(prev_q)) begin
                link_we    = 1'b1;
                link_waddr = prev_q[IDX_W-1:0];
                link_wdata = nxt;
              end else begin
                head_d = nxt;
              end
              if (cursor_q == c_q) begin
                cursor_d = nxt;
              end
              tgt_d   = c_q;
              c_d     = nxt;
              more_d  = !last;
              steps_d = steps_q + 1'b1;
              state_d = S_FREE;
            end else if (last) begin
              done_d  = 1'b1;
              rsp_d   = mk_rsp((op_q == OP_KILL_ALL) ? ST_OK : ST_NOT_FOUND, SLOT_NONE, '0);
              state_d = S_IDLE;
            end else begin
              prev_d  = c_q;
              c_d     = nxt;
              rd_addr = nxt[IDX_W-1:0];
              steps_d = steps_q + 1'b1;
            end
          end
          OP_FIND: begin
            if (match) begin
              done_d  = 1'b1;
              rsp_d   = mk_rsp(ST_OK, c_q, tag_rdata);
              state_d = S_IDLE;
            end else if (last) begin
              done_d  = 1'b1;
              rsp_d   = mk_rsp(ST_NOT_FOUND, SLOT_NONE, '0);
              state_d = S_IDLE;
            end else begin
              c_d     = nxt;
              rd_addr = nxt[IDX_W-1:0];
              steps_d = steps_q + 1'b1;
            end
          end
          default: begin
            // run next: count down sleep, dispatch the first runnable slot
            cursor_d = nxt;
            sc_we    = (sc_rdata != 16'd0);
            sc_wdata = sc_dec;
            if (sc_dec == 16'd0) begin
              cur_d   = c_q;
              done_d  = 1'b1;
              rsp_d   = mk_rsp(ST_OK, c_q, tag_rdata);
              state_d = S_IDLE;
            end else if (last) begin
              cursor_d = SLOT_NONE;
              done_d   = 1'b1;
              rsp_d    = mk_rsp(ST_FRAME_DONE, SLOT_NONE, '0);
              state_d  = S_IDLE;
            end else begin
              c_d     = nxt;
              rd_addr = nxt[IDX_W-1:0];
              steps_d = steps_q + 1'b1;
            end
          end
        endcase
      end

      // push the unlinked slot on the free list
      S_FREE: begin
        link_we = 1'b1;
        free_d  = tgt_q;
        case (op_q)
          OP_KILL_ALL: begin
            if (more_q) begin
              rd_addr = c_q[IDX_W-1:0];
              state_d = S_WALK;
            end else begin
              done_d  = 1'b1;
              rsp_d   = mk_rsp(ST_OK, SLOT_NONE, '0);
              state_d = S_IDLE;
            end
          end
          OP_KILL: begin
            if (self_q) begin
              cur_d = SLOT_NONE;
            end
            done_d  = 1'b1;
            rsp_d   = mk_rsp(self_q ? ST_KILLED_SELF : ST_OK, tgt_q, '0);
            state_d = S_IDLE;
          end
          default: begin
            cur_d   = SLOT_NONE;
            done_d  = 1'b1;
            rsp_d   = mk_rsp(ST_OK, tgt_q, '0);
            state_d = S_IDLE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, list heads and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      free_q   <= '0;
      head_q   <= SLOT_NONE;
      cur_q    <= SLOT_NONE;
      cursor_q <= SLOT_NONE;
      done_o   <= 1'b0;
      op_q     <= OP_CLEAR;
      c_q      <= SLOT_NONE;
      prev_q   <= SLOT_NONE;
      tgt_q    <= SLOT_NONE;
      steps_q  <= '0;
      self_q   <= 1'b0;
      more_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      free_q   <= free_d;
      head_q   <= head_d;
      cur_q    <= cur_d;
      cursor_q <= cursor_d;
      done_o   <= done_d;
      op_q     <= op_d;
      c_q      <= c_d;
      prev_q   <= prev_d;
      tgt_q    <= tgt_d;
      steps_q  <= steps_d;
      self_q   <= self_d;
      more_q   <= more_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    pid_q  <= pid_d;
    mask_q <= mask_d;
    rsp_q  <= rsp_d;
  end

  assign busy  = (state_q != S_IDLE);
  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ptsc_ram.sv =====
`default_nettype none
module ptsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptsc_link.sv =====
`default_nettype none
module ptsc_link
  import ptsc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clr_i,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  waddr_i,
  input  wire logic [LINK_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0]  raddr_i,
  output logic      [LINK_W-1:0] rdata_o
);

  logic [NUM_SLOTS-1:0] lv_q;
  logic [IDX_W-1:0]     raddr_q;
  logic [LINK_W-1:0]    ram_rdata;

  ptsc_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // track written entries; unwritten ones read as their successor index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q    <= '0;
      raddr_q <= '0;
    end else begin
      raddr_q <= raddr_i;
      if (clr_i) begin
        lv_q <= '0;
      end else if (we_i) begin
        lv_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = lv_q[raddr_q] ? ram_rdata : LINK_W'({1'b0, raddr_q} + 1'b1);

endmodule
`default_nettype wire

// ===== tb/sv/tb_process_table_scheduler.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_process_table_scheduler;
  import ptsc_pkg::*;

  // Scoreboard: shadow copy of the slot lists and the queue of predicted responses
  class sched_scoreboard;

    logic [LINK_W-1:0] link_q [NUM_SLOTS];
    logic [LINK_W-1:0] free_hd, act_hd, cur_slot, cursor;
    logic [31:0]       id_q   [NUM_SLOTS];
    logic [15:0]       nap_q  [NUM_SLOTS];
    logic [31:0]       tag_q  [NUM_SLOTS];
    rsp_t              rsp_due [$];
    int                n_err;

    function new();
      n_err = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        link_q[i] = LINK_W'(i + 1);
        id_q[i]   = '0;
        nap_q[i]  = '0;
        tag_q[i]  = '0;
      end
      free_hd  = '0;
      act_hd   = SLOT_NONE;
      cur_slot = SLOT_NONE;
      cursor   = SLOT_NONE;
    endfunction

    // Unlink slot s from the active list and push it on the free list
    function bit unlink(logic [LINK_W-1:0] s);
      logic [LINK_W-1:0] prv, at, nx;
      int n;
      prv = SLOT_NONE;
      at  = act_hd;
      n   = 0;
      if (s >= SLOT_NONE) return 0;
      while (at < SLOT_NONE && n < NUM_SLOTS) begin
        if (at == s) begin
          nx = link_q[s];
          if (prv < SLOT_NONE) link_q[prv] = nx;
          else act_hd = nx;
          if (cursor == s) cursor = nx;
          link_q[s] = free_hd;
          free_hd   = s;
          return 1;
        end
        prv = at;
        at  = link_q[at];
        n++;
      end
      return 0;
    endfunction

    // Work out the response of one accepted command and queue it
    function void note_transfer(req_t r);
      logic [2:0]        st;
      logic [LINK_W-1:0] rs, s, prv, at, nx;
      logic [31:0]       rt;
      int n;
      st = ST_OK;
      rs = SLOT_NONE;
      rt = '0;
      case (r.op)
        OP_CLEAR: begin
          wipe();
        end
        OP_CREATE, OP_CHILD: begin
          s = free_hd;
          if (s >= SLOT_NONE) begin
            st = ST_NO_FREE;
          end else begin
            free_hd   = link_q[s];
            link_q[s] = act_hd;
            act_hd    = s;
            nap_q[s]  = '0;
            id_q[s]   = r.proc_id;
            tag_q[s]  = r.task_tag;
            if (r.op == OP_CHILD && cur_slot < SLOT_NONE && cur_slot != s) begin
              act_hd           = link_q[s];
              link_q[s]        = link_q[cur_slot];
              link_q[cur_slot] = s;
            end
            rs = s;
          end
        end
        OP_KILL: begin
          s = {1'b0, r.slot};
          if (cur_slot < SLOT_NONE && s == cur_slot) begin
            void'(unlink(s));
            cur_slot = SLOT_NONE;
            st = ST_KILLED_SELF;
            rs = s;
          end else if (unlink(s)) begin
            rs = s;
          end else begin
            st = ST_NOT_FOUND;
          end
        end
        OP_KILL_ALL: begin
          prv = SLOT_NONE;
          at  = act_hd;
          n   = 0;
          while (at < SLOT_NONE && n < NUM_SLOTS) begin
            nx = link_q[at];
            if ((id_q[at] & r.id_mask) == (r.proc_id & r.id_mask) && at != cur_slot) begin
              if (prv < SLOT_NONE) link_q[prv] = nx;
              else act_hd = nx;
              if (cursor == at) cursor = nx;
              link_q[at] = free_hd;
              free_hd    = at;
            end else begin
              prv = at;
            end
            at = nx;
            n++;
          end
        end
        OP_FIND: begin
          at = act_hd;
          n  = 0;
          st = ST_NOT_FOUND;
          while (at < SLOT_NONE && n < NUM_SLOTS) begin
            if ((id_q[at] & r.id_mask) == (r.proc_id & r.id_mask)) begin
              st = ST_OK;
              rs = at;
              rt = tag_q[at];
              break;
            end
            at = link_q[at];
            n++;
          end
        end
        OP_FRAME: begin
          cursor   = act_hd;
          cur_slot = SLOT_NONE;
        end
        OP_RUN: begin
          n  = 0;
          st = ST_FRAME_DONE;
          cur_slot = SLOT_NONE;
          while (cursor < SLOT_NONE && n < NUM_SLOTS) begin
            s = cursor;
            cursor = link_q[s];
            if (nap_q[s] > 0) nap_q[s] = nap_q[s] - 16'd1;
            if (nap_q[s] == 0) begin
              cur_slot = s;
              st = ST_OK;
              rs = s;
              rt = tag_q[s];
              break;
            end
            n++;
          end
          if (st == ST_FRAME_DONE) cursor = SLOT_NONE;
        end
        OP_SLEEP: begin
          if (cur_slot >= SLOT_NONE) begin
            st = ST_NOT_FOUND;
          end else begin
            nap_q[cur_slot] = r.ticks;
            rs = cur_slot;
          end
        end
        OP_EXIT: begin
          if (cur_slot >= SLOT_NONE) begin
            st = ST_NOT_FOUND;
          end else begin
            rs = cur_slot;
            void'(unlink(cur_slot));
            cur_slot = SLOT_NONE;
          end
        end
        default: ;
      endcase
      rsp_due.push_back(mk_rsp(st, rs, rt));
    endfunction

    // Compare one response with the oldest prediction
    function void check_response(rsp_t got);
      rsp_t want;
      if (rsp_due.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected response %p", got);
        return;
      end
      want = rsp_due.pop_front();
      if (got.status !== want.status || got.result_slot !== want.result_slot ||
          got.result_tag !== want.result_tag) begin
        n_err++;
        if (n_err <= 10)
          $display("ERROR: status %0d/%0d slot %0d/%0d tag %h/%h (expected/actual)",
                   want.status, got.status, want.result_slot, got.result_slot,
                   want.result_tag, got.result_tag);
      end
    endfunction
  endclass

  localparam logic [3:0] OP_UNUSED = 4'hF;
  localparam int         CYC_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy, done_o;
  rsp_t rsp_o;
  int   cyc = 0;
  int   idle_pct = 0;
  sched_scoreboard sb;

  process_table_scheduler u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Take each response in its single strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_response(rsp_o);
  end

  // Hold the command until it transfers, then optionally idle
  task automatic issue(req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_transfer(r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_i <= req_t'($bits(req_t)'({$urandom, $urandom, $urandom, $urandom}));
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic cmd(logic [3:0] op, logic [31:0] tg, logic [31:0] pid,
                     logic [31:0] msk, logic [5:0] sl, logic [15:0] tk);
    req_t r;
    r.op = op; r.task_tag = tg; r.proc_id = pid;
    r.id_mask = msk; r.slot = sl; r.ticks = tk;
    issue(r);
  endtask

  // Let every predicted response come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.rsp_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random command, biased towards building and running task lists
  task automatic random_cmd();
    req_t r;
    int w;
    r = req_t'($bits(req_t)'({$urandom, $urandom, $urandom, $urandom}));
    w = $urandom_range(99);
    if      (w < 20) r.op = OP_CREATE;
    else if (w < 32) r.op = OP_CHILD;
    else if (w < 42) r.op = OP_KILL;
    else if (w < 46) r.op = OP_KILL_ALL;
    else if (w < 55) r.op = OP_FIND;
    else if (w < 61) r.op = OP_FRAME;
    else if (w < 79) r.op = OP_RUN;
    else if (w < 88) r.op = OP_SLEEP;
    else if (w < 95) r.op = OP_EXIT;
    else if (w < 96) r.op = OP_CLEAR;
    else r.op = 4'($urandom_range(10, 15));
    // keep ids in a small class space most of the time so masks match
    if ($urandom_range(3) != 0) r.proc_id = $urandom_range(0, 7);
    case ($urandom_range(3))
      0: r.id_mask = '1;
      1: r.id_mask = 32'h7;
      2: r.id_mask = '0;
      default: ;
    endcase
    if ($urandom_range(3) != 0) r.ticks = $urandom_range(0, 3);
    issue(r);
  endtask

  task automatic random_phase(int pct, int count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      // occasionally fill the pool to exhaust the free list
      if ($urandom_range(199) == 0) begin
        repeat (70) cmd(OP_CREATE, $urandom, $urandom_range(0, 7), '1, '0, '0);
        i += 69;
      end else begin
        random_cmd();
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes and special cases
    cmd(OP_SLEEP,    '0, '0, '0, '0, 16'd5);
    cmd(OP_EXIT,     '0, '0, '0, '0, '0);
    cmd(OP_RUN,      '0, '0, '0, '0, '0);
    cmd(OP_CHILD,    '1, '1, '0, '0, '0);
    cmd(OP_CREATE,   '0, '0, '1, '1, '1);
    cmd(OP_CREATE,   32'hA5A5_5A5A, 32'h5, '0, '0, '0);
    cmd(OP_FIND,     '0, '1, '1, '0, '0);
    cmd(OP_FIND,     '0, 32'h1234, '1, '0, '0);
    cmd(OP_FRAME,    '0, '0, '0, '0, '0);
    cmd(OP_RUN,      '0, '0, '0, '0, '0);
    cmd(OP_CHILD,    32'h1, 32'h5, '0, '0, '0);
    cmd(OP_SLEEP,    '0, '0, '0, '0, 16'hFFFF);
    cmd(OP_RUN,      '0, '0, '0, '0, '0);
    cmd(OP_KILL,     '0, '0, '0, 6'd1, '0);
    cmd(OP_KILL,     '0, '0, '0, 6'd63, '0);
    cmd(OP_KILL_ALL, '0, 32'h5, 32'h7, '0, '0);
    cmd(OP_FRAME,    '0, '0, '0, '0, '0);
    cmd(OP_RUN,      '0, '0, '0, '0, '0);
    cmd(OP_SLEEP,    '0, '0, '0, '0, 16'd0);
    cmd(OP_EXIT,     '0, '0, '0, '0, '0);
    cmd(OP_RUN,      '0, '0, '0, '0, '0);
    cmd(OP_UNUSED,   '1, '1, '1, '1, '1);
    cmd(OP_CLEAR,    '0, '0, '0, '0, '0);
    drain();

    // Random: no idling, heavy idling, light idling
    random_phase(0, 520);
    random_phase(82, 500);
    random_phase(27, 510);

    repeat (200) @(posedge clk_i);
    if (sb.n_err == 0 && sb.rsp_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

`default_nettype wire
